/* rtl/msc_pkg.sv */
package msc_pkg;

   // Command codes carried in the request word
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Fixed display constants
   localparam logic [4:0] BLANK_CODE       = 5'd16;
   localparam logic [4:0] RADIX_MIN        = 5'd2;
   localparam logic [4:0] RADIX_MAX        = 5'd16;
   localparam logic [4:0] RADIX_RESET      = 5'd10;
   localparam logic [9:0] TICKS_PER_CHANGE = 10'd1000;
   localparam logic [1:0] LAST_GLYPH       = 2'd3;    // four glyphs
   localparam int         NUMBER_WIDTH     = 16;
   localparam int         BITS_PER_STEP    = 4;
   localparam int         DIV_STEPS        = NUMBER_WIDTH / BITS_PER_STEP;

   // Request word
   typedef struct packed {
      logic        cmd;
      logic [15:0] number_value;
      logic        power_on;
      logic        hazard_enable;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [3:0] digit_select;
      logic [7:0] segment_drive;
      logic [7:0] row_select;
      logic [7:0] row_pattern;
      logic       hazard_lamp;
      logic       digit_overflow;
   } rsp_word_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic tick;    // process a tick word this cycle
      logic load;    // start a number load this cycle
      logic divide;  // run one division step
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic conv_last;  // this division step ends the conversion
   } dp_status_type;

   // Seven-segment patterns, codes 0..15 plus blank
   function automatic logic [7:0] seg_pattern(input logic [4:0] code);
      logic [7:0] pat;
      case (code)
         5'd0:    pat = 8'h3F;
         5'd1:    pat = 8'h06;
         5'd2:    pat = 8'h5B;
         5'd3:    pat = 8'h4F;
         5'd4:    pat = 8'h66;
         5'd5:    pat = 8'h6D;
         5'd6:    pat = 8'h7D;
         5'd7:    pat = 8'h07;
         5'd8:    pat = 8'h7F;
         5'd9:    pat = 8'h6F;
         5'd10:   pat = 8'h77;
         5'd11:   pat = 8'h7C;
         5'd12:   pat = 8'h58;
         5'd13:   pat = 8'h5E;
         5'd14:   pat = 8'h79;
         5'd15:   pat = 8'h71;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // Dot-matrix glyph rows
   function automatic logic [7:0] glyph_row(input logic [1:0] glyph, input logic [2:0] row);
      logic [7:0] pat;
      case ({glyph, row})
         5'd0:    pat = 8'hE7;
         5'd1:    pat = 8'h00;
         5'd2:    pat = 8'hDB;
         5'd3:    pat = 8'hBD;
         5'd4:    pat = 8'h7E;
         5'd5:    pat = 8'hE7;
         5'd6:    pat = 8'hE7;
         5'd7:    pat = 8'h00;
         5'd8:    pat = 8'h7E;
         5'd9:    pat = 8'h7E;
         5'd10:   pat = 8'h00;
         5'd11:   pat = 8'h7E;
         5'd12:   pat = 8'h00;
         5'd13:   pat = 8'hE7;
         5'd14:   pat = 8'hE7;
         5'd15:   pat = 8'h00;
         5'd16:   pat = 8'hE7;
         5'd17:   pat = 8'hDB;
         5'd18:   pat = 8'hE7;
         5'd19:   pat = 8'hFF;
         5'd20:   pat = 8'h00;
         5'd21:   pat = 8'hE7;
         5'd22:   pat = 8'h7F;
         5'd23:   pat = 8'h00;
         5'd24:   pat = 8'h06;
         5'd25:   pat = 8'hDE;
         5'd26:   pat = 8'hA8;
         5'd27:   pat = 8'h76;
         5'd28:   pat = 8'hFE;
         5'd29:   pat = 8'h7F;
         5'd30:   pat = 8'h7F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/msc_ctrl.sv */
module msc_ctrl
   import msc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Take a word only when idle and the output register is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      dp_cmd.tick   = 1'b0;
      dp_cmd.load   = 1'b0;
      dp_cmd.divide = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  dp_cmd.load = 1'b1;
                  state_in    = ST_DIVIDE;
               end else begin
                  dp_cmd.tick  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            dp_cmd.divide = 1'b1;
            if (dp_status.conv_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/msc_dp.sv */
module msc_dp
   import msc_pkg::*;
#(
   parameter int NUM_DIGITS        = 4,
   parameter int DIGIT_STORE_DEPTH = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_data,
   input  logic          csr_valid,
   input  logic [4:0]    csr_data,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   output rsp_word_type  rsp_data
);

   localparam int DPW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int SIW = (DIGIT_STORE_DEPTH > 1) ? $clog2(DIGIT_STORE_DEPTH) : 1;
   localparam int STW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   logic [4:0]           radix_ff;
   logic [4:0]           div_radix_ff, div_radix_in;
   logic [4:0]           store_ff [DIGIT_STORE_DEPTH];
   logic [DPW-1:0]       digit_ptr_ff, digit_ptr_in;
   logic [2:0]           row_ptr_ff, row_ptr_in;
   logic [1:0]           glyph_ff, glyph_in;
   logic [9:0]           tick_cnt_ff, tick_cnt_in;
   logic                 hazard_ff, hazard_in;
   logic [3:0]           held_sel_ff, held_sel_in;
   logic [7:0]           held_seg_ff, held_seg_in;
   logic [7:0]           held_pat_ff, held_pat_in;
   logic [SIW-1:0]       pos_ff;
   logic [STW-1:0]       step_ff;
   logic [4:0]           rem_ff, rem_v;
   logic [15:0]          quo_ff, quo_v;
   logic [5:0]           trial;
   logic [4:0]           code;
   logic                 step_last, pos_last, conv_last;
   rsp_word_type         rsp_ff, rsp_in;

   // Radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_data;
      end
   end

   // Clamp radix into the supported range at load start
   always_comb begin
      div_radix_in = div_radix_ff;
      if (dp_cmd.load) begin
         if (radix_ff < RADIX_MIN) begin
            div_radix_in = RADIX_MIN;
         end else if (radix_ff > RADIX_MAX) begin
            div_radix_in = RADIX_MAX;
         end else begin
            div_radix_in = radix_ff;
         end
      end
   end

   // One division step: BITS_PER_STEP restoring compare-subtract bits
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         trial = {rem_v, quo_v[15]};
         quo_v = {quo_v[14:0], 1'b0};
         if (trial >= {1'b0, div_radix_ff}) begin
            rem_v    = 5'(trial - {1'b0, div_radix_ff});
            quo_v[0] = 1'b1;
         end else begin
            rem_v = trial[4:0];
         end
      end
   end

   assign step_last = (step_ff == STW'(DIV_STEPS - 1));
   assign pos_last  = (int'(pos_ff) == DIGIT_STORE_DEPTH - 1);
   assign conv_last = step_last && ((quo_v == '0) || pos_last);
   assign dp_status.conv_last = conv_last;

   // Divider registers and digit store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_STORE_DEPTH; i++) begin
            store_ff[i] <= BLANK_CODE;
         end
      end else if (dp_cmd.load) begin
         for (int i = 1; i < DIGIT_STORE_DEPTH; i++) begin
            store_ff[i] <= BLANK_CODE;
         end
      end else if (dp_cmd.divide && step_last) begin
         store_ff[pos_ff] <= rem_v;
      end
   end

   always_ff @(posedge clock) begin
      div_radix_ff <= div_radix_in;
      if (dp_cmd.load) begin
         pos_ff  <= '0;
         step_ff <= '0;
         rem_ff  <= '0;
         quo_ff  <= req_data.number_value;
      end else if (dp_cmd.divide) begin
         quo_ff <= quo_v;
         if (step_last) begin
            step_ff <= '0;
            rem_ff  <= '0;
            if (!conv_last) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end else begin
            step_ff <= step_ff + 1'b1;
            rem_ff  <= rem_v;
         end
      end
   end

   // Digit code for the selected position; missing or bad codes show blank
   always_comb begin
      code = BLANK_CODE;
      for (int i = 0; i < DIGIT_STORE_DEPTH; i++) begin
         if (int'(digit_ptr_ff) == i) begin
            code = store_ff[i];
         end
      end
      if (code > BLANK_CODE) begin
         code = BLANK_CODE;
      end
   end

   // Tick processing
   always_comb begin
      digit_ptr_in = digit_ptr_ff;
      row_ptr_in   = row_ptr_ff;
      glyph_in     = glyph_ff;
      tick_cnt_in  = tick_cnt_ff;
      hazard_in    = hazard_ff;
      held_sel_in  = held_sel_ff;
      held_seg_in  = held_seg_ff;
      held_pat_in  = held_pat_ff;
      if (dp_cmd.tick) begin
         if (req_data.power_on) begin
            // digit scan
            held_sel_in = 4'hF;
            for (int i = 0; i < 4; i++) begin
               if (int'(digit_ptr_ff) == i) begin
                  held_sel_in[i] = 1'b0;
               end
            end
            held_seg_in = ~seg_pattern(code);
            if (int'(digit_ptr_ff) == NUM_DIGITS - 1) begin
               digit_ptr_in = '0;
            end else begin
               digit_ptr_in = digit_ptr_ff + 1'b1;
            end
            // matrix row, advanced before use
            row_ptr_in  = row_ptr_ff + 3'd1;
            held_pat_in = glyph_row(glyph_ff, row_ptr_in);
            // glyph and hazard timing
            tick_cnt_in = tick_cnt_ff + 10'd1;
            if (tick_cnt_in == TICKS_PER_CHANGE) begin
               tick_cnt_in = '0;
               glyph_in    = (glyph_ff == LAST_GLYPH) ? 2'd0 : glyph_ff + 2'd1;
               if (req_data.hazard_enable) begin
                  hazard_in = !hazard_ff;
               end
            end
         end else begin
            row_ptr_in  = '0;
            glyph_in    = '0;
            held_seg_in = 8'hFF;
            held_pat_in = 8'hFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ptr_ff <= '0;
         row_ptr_ff   <= '0;
         glyph_ff     <= '0;
         tick_cnt_ff  <= '0;
         hazard_ff    <= 1'b0;
         held_sel_ff  <= 4'hF;
         held_seg_ff  <= 8'hFF;
         held_pat_ff  <= 8'hFF;
      end else begin
         digit_ptr_ff <= digit_ptr_in;
         row_ptr_ff   <= row_ptr_in;
         glyph_ff     <= glyph_in;
         tick_cnt_ff  <= tick_cnt_in;
         hazard_ff    <= hazard_in;
         held_sel_ff  <= held_sel_in;
         held_seg_ff  <= held_seg_in;
         held_pat_ff  <= held_pat_in;
      end
   end

   // Output register: loaded on a tick or at the end of a conversion
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_in.digit_select   = held_sel_in;
      rsp_in.segment_drive  = held_seg_in;
      rsp_in.row_select     = 8'(9'd1 << row_ptr_in);
      rsp_in.row_pattern    = held_pat_in;
      rsp_in.hazard_lamp    = hazard_in;
      rsp_in.digit_overflow = dp_cmd.divide && (quo_v != '0);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.tick || (dp_cmd.divide && conv_last)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/multiplexed_display_scanner_top.sv */
// Channel  | Ports                          | Word
// ---------+--------------------------------+----------------------------
// request  | req_valid, req_ready, req_data | cmd, number, power, hazard
// response | rsp_valid, rsp_ready, rsp_data | selects, patterns, lamp, ovf
// csr      | csr_valid, csr_ready, csr_data | digit radix (5 bits)
//
// A tick word's response is valid in the cycle after acceptance.
// A load word runs through the 4-bit-per-cycle divider, one digit per pass,
// for 1 to DIGIT_STORE_DEPTH digits (5 by default).
// Synchronous active-high reset; no clearing pass is needed.
// A new word is taken while the response register is being drained.
module multiplexed_display_scanner_top
   import msc_pkg::*;
#(
   parameter int NUM_DIGITS        = 4,
   parameter int DIGIT_STORE_DEPTH = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Radix writes must arrive only while idle; the block itself does not enforce it
   assign csr_ready = 1'b1;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   msc_dp #(
      .NUM_DIGITS        (NUM_DIGITS),
      .DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import msc_pkg::*;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 25;
   localparam int STORE_DEPTH   = 5;
   localparam int MAX_REPORTS   = 100;
   localparam int PHASE_WORDS   = 30;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = '0;

   // idle / stall percentages for the current phase
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // long receiver hold-off, requested by toggling hold_toggle
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;

   int mismatches  = 0;
   int cycle_count = 0;

   // display words still owed by the block, oldest first
   rsp_word_type pending_display[$];

   // scanner model state
   logic [4:0] radix_setting;
   logic [4:0] store_digits [STORE_DEPTH];
   logic [1:0] scan_digit;
   logic [2:0] scan_row;
   logic [1:0] scan_glyph;
   logic [9:0] ms_count;
   logic       lamp_phase;
   logic [3:0] hold_select;
   logic [7:0] hold_segment;
   logic [7:0] hold_row;

   // segment patterns for codes 0..15, then blank
   logic [7:0] seg_table [17] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h00
   };

   // glyph rows, indexed by {glyph, row}
   logic [7:0] glyph_table [32] = '{
      8'hE7, 8'h00, 8'hDB, 8'hBD, 8'h7E, 8'hE7, 8'hE7, 8'h00,
      8'h7E, 8'h7E, 8'h00, 8'h7E, 8'h00, 8'hE7, 8'hE7, 8'h00,
      8'hE7, 8'hDB, 8'hE7, 8'hFF, 8'h00, 8'hE7, 8'h7F, 8'h00,
      8'h06, 8'hDE, 8'hA8, 8'h76, 8'hFE, 8'h7F, 8'h7F, 8'h00
   };

   multiplexed_display_scanner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the scanner model by one word and return the display it shows
   function automatic rsp_word_type next_display(input req_word_type w);
      rsp_word_type r;
      logic [4:0]   base;
      logic [4:0]   code;
      int unsigned  num;
      int           j;
      r.digit_overflow = 1'b0;
      if (w.cmd == CMD_LOAD) begin
         base = radix_setting;
         if (base < RADIX_MIN) base = RADIX_MIN;
         if (base > RADIX_MAX) base = RADIX_MAX;
         for (j = 1; j < STORE_DEPTH; j++) store_digits[j] = BLANK_CODE;
         num = w.number_value;
         j = 0;
         do begin
            store_digits[j] = 5'(num % base);
            num = num / base;
            j++;
         end while (num != 0 && j < STORE_DEPTH);
         r.digit_overflow = (num != 0);
      end else if (w.power_on) begin
         hold_select = ~(4'b0001 << scan_digit);
         code = store_digits[scan_digit];
         if (code > BLANK_CODE) code = BLANK_CODE;
         hold_segment = ~seg_table[code];
         scan_digit = scan_digit + 2'd1;
         // row pointer moves before it is used
         scan_row = scan_row + 3'd1;
         hold_row = glyph_table[{scan_glyph, scan_row}];
         ms_count = ms_count + 10'd1;
         if (ms_count == TICKS_PER_CHANGE) begin
            ms_count = '0;
            scan_glyph = scan_glyph + 2'd1;
            if (w.hazard_enable) lamp_phase = ~lamp_phase;
         end
      end else begin
         // power off: matrix restarts, outputs blank, counters hold
         scan_row = '0;
         scan_glyph = '0;
         hold_segment = 8'hFF;
         hold_row = 8'hFF;
      end
      r.digit_select  = hold_select;
      r.segment_drive = hold_segment;
      r.row_select    = 8'd1 << scan_row;
      r.row_pattern   = hold_row;
      r.hazard_lamp   = lamp_phase;
      return r;
   endfunction

   function automatic req_word_type make_word(input logic c, input logic [15:0] n,
                                              input logic p, input logic h);
      req_word_type w;
      w.cmd           = c;
      w.number_value  = n;
      w.power_on      = p;
      w.hazard_enable = h;
      return w;
   endfunction

   // Mostly ticks with power on; numbers biased toward short digit strings
   function automatic req_word_type random_word();
      logic [15:0] n;
      case ($urandom_range(0, 3))
         0:       n = 16'($urandom_range(0, 15));
         1:       n = 16'($urandom_range(0, 255));
         default: n = 16'($urandom_range(0, 65535));
      endcase
      return make_word(($urandom_range(0, 99) < 30) ? CMD_LOAD : CMD_TICK, n,
                       $urandom_range(0, 99) < 80, 1'($urandom_range(0, 1)));
   endfunction

   // Offer one word; valid stays up across back-to-back words
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_display.push_back(next_display(w));
   endtask

   task automatic wait_drained(input int pause);
      req_valid <= 1'b0;
      while (pending_display.size() != 0) @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   // Radix writes happen only with the block idle
   task automatic write_radix(input logic [4:0] v);
      wait_drained(4);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      radix_setting = v;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Decimal conversion from reset, blank digits, power-off from reset
   task automatic test_digit_conversion();
      send_word(make_word(CMD_TICK, 16'h1234, 1'b0, 1'b0));
      send_word(make_word(CMD_TICK, 16'h0000, 1'b1, 1'b0));
      send_word(make_word(CMD_LOAD, 16'd0, 1'b1, 1'b0));
      repeat (4) send_word(make_word(CMD_TICK, 16'hFFFF, 1'b1, 1'b1));
      send_word(make_word(CMD_LOAD, 16'd65535, 1'b0, 1'b1));
      repeat (4) send_word(make_word(CMD_TICK, 16'h0000, 1'b1, 1'b0));
   endtask

   // Radix at both ends and clamped from outside the legal range
   task automatic test_radix_extremes();
      write_radix(RADIX_MIN);
      send_word(make_word(CMD_LOAD, 16'd65535, 1'b1, 1'b0));  // overflows
      send_word(make_word(CMD_LOAD, 16'd31, 1'b1, 1'b0));     // fills store exactly
      send_word(make_word(CMD_LOAD, 16'd32, 1'b1, 1'b0));     // one digit too many
      send_word(make_word(CMD_TICK, 16'd0, 1'b1, 1'b0));
      write_radix(RADIX_MAX);
      send_word(make_word(CMD_LOAD, 16'd65535, 1'b1, 1'b0));
      repeat (2) send_word(make_word(CMD_TICK, 16'd0, 1'b1, 1'b0));
      write_radix(5'd0);
      send_word(make_word(CMD_LOAD, 16'd5, 1'b1, 1'b0));
      send_word(make_word(CMD_TICK, 16'd0, 1'b1, 1'b0));
      write_radix(5'd31);
      send_word(make_word(CMD_LOAD, 16'hABCD, 1'b1, 1'b0));
      send_word(make_word(CMD_TICK, 16'd0, 1'b1, 1'b0));
      write_radix(5'd17);
      send_word(make_word(CMD_LOAD, 16'd100, 1'b0, 1'b1));
   endtask

   // A full glyph period of ticks; hazard enable at the glyph change is set unless the glyph is 1
   task automatic test_glyph_rollover();
      logic haz;
      for (int i = 0; i < 1000 + 8; i++) begin
         if (ms_count == TICKS_PER_CHANGE - 10'd1) haz = (scan_glyph != 2'd1);
         else haz = 1'($urandom_range(0, 1));
         send_word(make_word(CMD_TICK, 16'($urandom), 1'b1, haz));
      end
   endtask

   // Receiver holds off while words keep coming, so the input stalls
   task automatic test_backpressure();
      hold_toggle <= ~hold_toggle;
      repeat (16) send_word(random_word());
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      write_radix(5'($urandom_range(0, 31)));
      repeat (PHASE_WORDS) send_word(random_word());
   endtask

   // Response ready: random stalls, or a counted hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each accepted display word with the oldest owed one
   always @(posedge clock) begin : check_display
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_display.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("%0t: no word expected, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = pending_display.pop_front();
            check_field("digit_select", want.digit_select, rsp_data.digit_select);
            check_field("segment_drive", want.segment_drive, rsp_data.segment_drive);
            check_field("row_select", want.row_select, rsp_data.row_select);
            check_field("row_pattern", want.row_pattern, rsp_data.row_pattern);
            check_field("hazard_lamp", want.hazard_lamp, rsp_data.hazard_lamp);
            check_field("digit_overflow", want.digit_overflow, rsp_data.digit_overflow);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      radix_setting = RADIX_RESET;
      for (int j = 0; j < STORE_DEPTH; j++) store_digits[j] = BLANK_CODE;
      scan_digit   = '0;
      scan_row     = '0;
      scan_glyph   = '0;
      ms_count     = '0;
      lamp_phase   = 1'b0;
      hold_select  = 4'hF;
      hold_segment = 8'hFF;
      hold_row     = 8'hFF;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_digit_conversion();
      test_radix_extremes();
      test_glyph_rollover();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(60, 0);
      test_random_traffic(0, 60);
      test_random_traffic(17, 17);

      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0 && pending_display.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/msc_pkg.sv
rtl/msc_ctrl.sv
rtl/msc_dp.sv
rtl/multiplexed_display_scanner_top.sv
tb/testbench.sv
